/* rtl/core/pnt_pkg.sv */
// Package for the prefixed number text parser.
// Holds the parse phase and radix types, character codes and the step result struct.
// No dependencies.
package pnt_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned CountW = 8;
    localparam int unsigned OutW   = 32;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ZERO = 3'd1,
        PH_DEC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_OCT  = 3'd4,
        PH_BIN  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    localparam logic [CharW-1:0] CH_0  = 8'h30;
    localparam logic [CharW-1:0] CH_1  = 8'h31;
    localparam logic [CharW-1:0] CH_7  = 8'h37;
    localparam logic [CharW-1:0] CH_9  = 8'h39;
    localparam logic [CharW-1:0] CH_UA = 8'h41;
    localparam logic [CharW-1:0] CH_UF = 8'h46;
    localparam logic [CharW-1:0] CH_LA = 8'h61;
    localparam logic [CharW-1:0] CH_LF = 8'h66;
    localparam logic [CharW-1:0] CH_UX = 8'h58;
    localparam logic [CharW-1:0] CH_LX = 8'h78;
    localparam logic [CharW-1:0] CH_UB = 8'h42;
    localparam logic [CharW-1:0] CH_LB = 8'h62;
    localparam logic [CharW-1:0] CH_UO = 8'h4F;
    localparam logic [CharW-1:0] CH_LO = 8'h6F;

    localparam logic [CountW-1:0] CountMax = 8'hFF;

    // one finished number, as presented on the result channel
    typedef struct packed {
        logic [OutW-1:0]   value;
        logic [CountW-1:0] count;
        radix_t            radix;
        logic              at_limit;
    } result_t;

    function automatic radix_t radix_of(input phase_t ph);
        radix_t r;
        unique case (ph)
            PH_HEX:  r = RADIX_HEX;
            PH_OCT:  r = RADIX_OCT;
            PH_BIN:  r = RADIX_BIN;
            default: r = RADIX_DEC;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/pnt_char_if.sv */
// Character input channel: valid/ready handshake with one text byte.
// Depends on pnt_pkg.
interface pnt_char_if
    import pnt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] char_code;
    logic             last_in_buffer;

    modport source (output valid, output char_code, output last_in_buffer, input ready);
    modport sink   (input valid, input char_code, input last_in_buffer, output ready);
endinterface

/* rtl/core/pnt_num_if.sv */
// Result channel: valid/ready handshake with one parsed number.
// Depends on pnt_pkg.
interface pnt_num_if
    import pnt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OutW-1:0]   parsed_value;
    logic [CountW-1:0] chars_consumed;
    logic [1:0]        radix_code;
    logic              stopped_at_limit;

    modport source (output valid, output parsed_value, output chars_consumed,
                    output radix_code, output stopped_at_limit, input ready);
    modport sink   (input valid, input parsed_value, input chars_consumed,
                    input radix_code, input stopped_at_limit, output ready);
endinterface

/* rtl/core/prefixed_number_text_parser.sv */
// Top level of the prefixed number text parser: parse state and result register.
// Depends on pnt_pkg, pnt_char_if, pnt_num_if and pnt_step.
//
//  channel   dir   handshake     payload
//  chars     in    valid/ready   char_code[7:0], last_in_buffer
//  numbers   out   valid/ready   parsed_value[31:0], chars_consumed[7:0],
//                                radix_code[1:0], stopped_at_limit
//
// One character per cycle: the whole step is a shift-and-add on the
// accumulator plus phase decode, done between the parse state and the
// result register. A number appears on numbers in the cycle after the
// transfer of the character that ends it. chars stays ready while the
// result register is empty or being drained; it stalls only when a
// result is held. Reset returns the parser to idle with nothing pending.
module prefixed_number_text_parser
    import pnt_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
)(
    input  logic       clk,
    input  logic       rst_n,
    pnt_char_if.sink   chars,
    pnt_num_if.source  numbers
);
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [CountW-1:0]      count_reg;
    logic [CountW-1:0]      count_next;
    logic                   emit;
    result_t                result;
    result_t                out_reg;
    logic                   out_valid_reg;
    logic                   take;

    assign chars.ready = !out_valid_reg || numbers.ready;
    assign take        = chars.valid && chars.ready;

    pnt_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .char_code      (chars.char_code),
        .last_in_buffer (chars.last_in_buffer),
        .phase          (phase_reg),
        .acc            (acc_reg),
        .count          (count_reg),
        .phase_next     (phase_next),
        .acc_next       (acc_next),
        .count_next     (count_next),
        .emit           (emit),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            count_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (chars.ready) begin
            out_valid_reg <= take && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit) begin
            out_reg <= result;
        end
    end

    assign numbers.valid            = out_valid_reg;
    assign numbers.parsed_value     = out_reg.value;
    assign numbers.chars_consumed   = out_reg.count;
    assign numbers.radix_code       = out_reg.radix;
    assign numbers.stopped_at_limit = out_reg.at_limit;

endmodule

/* rtl/core/pnt_step.sv */
// Per-character parse step: digit decode, shift-and-add, phase transitions.
// Purely combinational; depends on pnt_pkg.
module pnt_step
    import pnt_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
)(
    input  logic [CharW-1:0]       char_code,
    input  logic                   last_in_buffer,
    input  phase_t                 phase,
    input  logic [VALUE_WIDTH-1:0] acc,
    input  logic [CountW-1:0]      count,
    output phase_t                 phase_next,
    output logic [VALUE_WIDTH-1:0] acc_next,
    output logic [CountW-1:0]      count_next,
    output logic                   emit,
    output result_t                result
);
    localparam int unsigned ExtW = (VALUE_WIDTH > OutW) ? VALUE_WIDTH : OutW;

    logic                   is_dec;
    logic                   is_oct;
    logic                   is_bin;
    logic                   is_lhex;
    logic                   is_uhex;
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] acc_dec;
    logic [VALUE_WIDTH-1:0] acc_hex;
    logic [VALUE_WIDTH-1:0] acc_oct;
    logic [VALUE_WIDTH-1:0] acc_bin;
    logic [CountW-1:0]      count_inc;
    phase_t                 ph_n;
    logic [VALUE_WIDTH-1:0] acc_n;
    logic [CountW-1:0]      cnt_n;
    logic                   invalid;
    logic [ExtW-1:0]        acc_ext;

    assign is_dec  = (char_code >= CH_0) && (char_code <= CH_9);
    assign is_oct  = (char_code >= CH_0) && (char_code <= CH_7);
    assign is_bin  = (char_code == CH_0) || (char_code == CH_1);
    assign is_lhex = (char_code >= CH_LA) && (char_code <= CH_LF);
    assign is_uhex = (char_code >= CH_UA) && (char_code <= CH_UF);

    // letters a-f / A-F have low nibble 1..6, so value is nibble + 9
    assign digit = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);

    assign acc_dec = (acc << 3) + (acc << 1) + VALUE_WIDTH'(digit);
    assign acc_hex = (acc << 4) + VALUE_WIDTH'(digit);
    assign acc_oct = (acc << 3) + VALUE_WIDTH'(digit);
    assign acc_bin = (acc << 1) + VALUE_WIDTH'(digit);

    assign count_inc = (count == CountMax) ? count : count + CountW'(1);

    always_comb
    begin
        ph_n    = phase;
        acc_n   = acc;
        cnt_n   = count;
        invalid = 1'b0;
        unique case (phase)
            PH_ZERO:
            begin
                if ((char_code == CH_LX) || (char_code == CH_UX)) begin
                    ph_n  = PH_HEX;
                    cnt_n = count_inc;
                end else if ((char_code == CH_LB) || (char_code == CH_UB)) begin
                    ph_n  = PH_BIN;
                    cnt_n = count_inc;
                end else if ((char_code == CH_LO) || (char_code == CH_UO)) begin
                    ph_n  = PH_OCT;
                    cnt_n = count_inc;
                end else if (is_dec) begin
                    ph_n  = PH_DEC;
                    acc_n = acc_dec;
                    cnt_n = count_inc;
                end else begin
                    invalid = 1'b1;
                end
            end
            PH_DEC:
            begin
                if (is_dec) begin
                    acc_n = acc_dec;
                    cnt_n = count_inc;
                end else begin
                    invalid = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (is_dec || is_lhex || is_uhex) begin
                    acc_n = acc_hex;
                    cnt_n = count_inc;
                end else begin
                    invalid = 1'b1;
                end
            end
            PH_OCT:
            begin
                if (is_oct) begin
                    acc_n = acc_oct;
                    cnt_n = count_inc;
                end else begin
                    invalid = 1'b1;
                end
            end
            PH_BIN:
            begin
                if (is_bin) begin
                    acc_n = acc_bin;
                    cnt_n = count_inc;
                end else begin
                    invalid = 1'b1;
                end
            end
            default:
            begin
                // idle and unused codes: start a fresh number
                ph_n  = PH_IDLE;
                acc_n = '0;
                cnt_n = '0;
                if (is_dec) begin
                    acc_n = VALUE_WIDTH'(digit);
                    cnt_n = CountW'(1);
                    ph_n  = (char_code == CH_0) ? PH_ZERO : PH_DEC;
                end else begin
                    invalid = 1'b1;
                end
            end
        endcase
    end

    assign emit    = invalid || last_in_buffer;
    assign acc_ext = ExtW'(acc_n);

    assign result.value    = acc_ext[OutW-1:0];
    assign result.count    = cnt_n;
    assign result.radix    = radix_of(ph_n);
    assign result.at_limit = !invalid;

    assign phase_next = emit ? PH_IDLE : ph_n;
    assign acc_next   = emit ? '0 : acc_n;
    assign count_next = emit ? '0 : cnt_n;

endmodule
